/* hdl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// overlapping implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/lsrf_pkg.sv */
// Shared constants of the load segment record framer.
`default_nettype none
package lsrf_pkg;
  localparam int MAX_RUN_DEF = 32;
  localparam int CFG_W       = 16;
  localparam int ADDR_W      = 16;

  localparam logic [7:0] TYPE_DATA  = 8'h01;
  localparam logic [7:0] TYPE_ENTRY = 8'h02;

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic REG_HAS_ENTRY  = 1'b0;
  localparam logic REG_ENTRY_ADDR = 1'b1;

  localparam logic [2:0] HDR_LAST = 3'd4;
endpackage
`default_nettype wire

/* hdl/lsrf_if.sv */
// Request channels: input items and encoded output bytes.
`default_nettype none
interface lsrf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] address;
  logic [7:0]  data_byte;
  modport source (output valid, action, address, data_byte, input ready);
  modport sink   (input valid, action, address, data_byte, output ready);
endinterface

interface lsrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

/* hdl/load_segment_record_framer.sv */
// Load segment record framer: gathers contiguous byte runs and frames them as records.
// A data byte that extends the open run is taken and causes no output.
// A request that closes an n-byte run holds off the next request while it is framed:
// accept, 5 header bytes, a buffer read, n run bytes; an entry record adds 5 header bytes.
// A flush with only an entry record sends 5 header bytes; output stalls stretch each step.
// Synchronous reset clears the open run, the registers and both valid flags.
`default_nettype none
`include "assert_macros.svh"
module load_segment_record_framer #(
  parameter int MAX_RUN = lsrf_pkg::MAX_RUN_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [lsrf_pkg::CFG_W-1:0] cfg_data,
  lsrf_in_if.sink                       in_ch,
  lsrf_out_if.source                    out_ch
);
  import lsrf_pkg::*;

  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int IDX_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  typedef enum logic [1:0] {S_IDLE, S_HDR, S_BODY} state_t;

  state_t              state;
  logic [CNT_W-1:0]    run_count;
  logic [ADDR_W-1:0]   run_start;
  logic                has_entry;
  logic [ADDR_W-1:0]   entry_address;
  logic [2:0]          hidx;
  logic                hdr_entry;
  logic                flush_item;
  logic [ADDR_W-1:0]   pend_addr;
  logic [7:0]          pend_data;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    wr_cnt;
  logic                q_valid;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                out_last;

  logic [7:0]          mem [MAX_RUN];
  logic [7:0]          mem_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [7:0]          mem_wd;
  logic                rd_en;

  logic                accept;
  logic                out_free;
  logic                out_load;
  logic                contiguous;
  logic                run_full;
  logic                breaks_run;
  logic                run_append;
  logic                consume;
  logic                body_end;
  logic [7:0]          hdr_byte;
  logic [ADDR_W-1:0]   hdr_addr;
  logic [ADDR_W-1:0]   hdr_len;

  assign in_ch.ready        = (state == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = out_last;
  assign out_free           = !out_valid || out_ch.ready;

  // 17-bit sum: a run ending at 0xFFFF never matches address 0
  assign contiguous = ({1'b0, run_start} + {{(ADDR_W + 1 - CNT_W){1'b0}}, run_count})
                      == {1'b0, in_ch.address};
  assign run_full   = (run_count >= CNT_W'(MAX_RUN));
  assign breaks_run = (run_count != '0) && (!contiguous || run_full);
  assign run_append = accept && (in_ch.action == ACT_DATA) && !breaks_run;

  assign consume  = (state == S_BODY) && q_valid && out_free;
  assign body_end = consume && (wr_cnt == run_count - CNT_W'(1));
  assign rd_en    = (state == S_BODY) && (rd_idx < run_count) && (!q_valid || consume);
  assign out_load = ((state == S_HDR) && out_free) || consume;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = run_count[IDX_W-1:0];
    mem_wd = in_ch.data_byte;
    if (run_append) begin
      mem_we = 1'b1;
    end else if (body_end && !flush_item) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = pend_data;
    end
  end

  always_comb begin
    hdr_addr = hdr_entry ? entry_address : run_start;
    hdr_len  = hdr_entry ? '0 : {{(ADDR_W - CNT_W){1'b0}}, run_count};
    unique case (hidx)
      3'd0:    hdr_byte = hdr_entry ? TYPE_ENTRY : TYPE_DATA;
      3'd1:    hdr_byte = hdr_addr[7:0];
      3'd2:    hdr_byte = hdr_addr[15:8];
      3'd3:    hdr_byte = hdr_len[7:0];
      3'd4:    hdr_byte = hdr_len[15:8];
      default: hdr_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) mem_q <= mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_entry     <= 1'b0;
      entry_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HAS_ENTRY:  has_entry     <= cfg_data[0];
        REG_ENTRY_ADDR: entry_address <= cfg_data[ADDR_W-1:0];
        default:        has_entry     <= has_entry;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      run_count <= '0;
      run_start <= '0;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
      hidx      <= '0;
      hdr_entry <= 1'b0;
      flush_item <= 1'b0;
      rd_idx    <= '0;
      wr_cnt    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_addr  <= in_ch.address;
            pend_data  <= in_ch.data_byte;
            flush_item <= (in_ch.action == ACT_FLUSH);
            hidx       <= '0;
            if (in_ch.action == ACT_DATA) begin
              if (breaks_run) begin
                hdr_entry <= 1'b0;
                state     <= S_HDR;
              end else begin
                if (run_count == '0) run_start <= in_ch.address;
                run_count <= run_count + CNT_W'(1);
              end
            end else if (run_count != '0) begin
              hdr_entry <= 1'b0;
              state     <= S_HDR;
            end else if (has_entry) begin
              hdr_entry <= 1'b1;
              state     <= S_HDR;
            end
          end
        end
        S_HDR: begin
          if (out_free) begin
            out_byte  <= hdr_byte;
            out_last  <= hdr_entry && (hidx == HDR_LAST);
            hidx      <= hidx + 3'd1;
            if (hidx == HDR_LAST) begin
              rd_idx <= '0;
              wr_cnt <= '0;
              state  <= hdr_entry ? S_IDLE : S_BODY;
            end
          end
        end
        S_BODY: begin
          if (rd_en) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            q_valid <= 1'b1;
          end else if (consume) begin
            q_valid <= 1'b0;
          end
          if (consume) begin
            out_byte  <= mem_q;
            out_last  <= body_end && !(flush_item && has_entry);
            wr_cnt    <= wr_cnt + CNT_W'(1);
          end
          if (body_end) begin
            hidx <= '0;
            if (flush_item) begin
              run_count <= '0;
              hdr_entry <= 1'b1;
              state     <= has_entry ? S_HDR : S_IDLE;
            end else begin
              run_count <= CNT_W'(1);
              run_start <= pend_addr;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, run_count <= CNT_W'(MAX_RUN))
  `ASSERT_IMPL(a_q_in_body, clk, rst, q_valid, state == S_BODY)
  `ASSERT_IMPL(a_reads_track, clk, rst, state == S_BODY, rd_idx == wr_cnt + CNT_W'(q_valid))
  `ASSERT_NEXT(a_append, clk, rst, run_append, run_count == CNT_W'($past(run_count) + CNT_W'(1)))
endmodule
`default_nettype wire

/* tb/lsrf_model_pkg.sv */
// Record stream predictor and scoreboard for the load segment record framer test.
package lsrf_model_pkg;
  import lsrf_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } framed_byte_t;

  class record_stream_model;
    logic [7:0]   run_bytes [MAX_RUN_DEF];
    logic [15:0]  run_base;
    int unsigned  run_len;
    logic         entry_on;
    logic [15:0]  entry_at;
    framed_byte_t pending_bytes [$];
    int unsigned  error_count;

    function new();
      run_base    = '0;
      run_len     = 0;
      entry_on    = 1'b0;
      entry_at    = '0;
      error_count = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == REG_HAS_ENTRY) begin
        entry_on = val[0];
      end else begin
        entry_at = val;
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction

    local function void push_byte(logic [7:0] val);
      framed_byte_t fb;
      fb.value = val;
      fb.last  = 1'b0;
      pending_bytes = {pending_bytes, fb};
    endfunction

    local function void push_header(logic [7:0] kind, logic [15:0] addr, logic [15:0] len);
      push_byte(kind);
      push_byte(addr[7:0]);
      push_byte(addr[15:8]);
      push_byte(len[7:0]);
      push_byte(len[15:8]);
    endfunction

    local function void close_run();
      if (run_len == 0) return;
      push_header(TYPE_DATA, run_base, 16'(run_len));
      for (int unsigned i = 0; i < run_len; i++) push_byte(run_bytes[i]);
      run_len = 0;
    endfunction

    // Called once per accepted request; queues every byte it frames.
    function void take_item(logic act, logic [15:0] addr, logic [7:0] dat);
      int unsigned  first;
      framed_byte_t tail;
      first = pending_bytes.size();
      if (act == ACT_DATA) begin
        // 32-bit sum: a run ending at 0xFFFF never continues at 0x0000
        if (run_len != 0 && (({16'd0, run_base} + run_len != {16'd0, addr}) ||
                             run_len >= MAX_RUN_DEF)) begin
          close_run();
        end
        if (run_len == 0) run_base = addr;
        run_bytes[run_len] = dat;
        run_len++;
      end else begin
        close_run();
        if (entry_on) push_header(TYPE_ENTRY, entry_at, 16'd0);
      end
      if (pending_bytes.size() > first) begin
        tail = pending_bytes[pending_bytes.size() - 1];
        tail.last = 1'b1;
        pending_bytes[pending_bytes.size() - 1] = tail;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endtask

    task check_byte(logic [7:0] val, logic last);
      framed_byte_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last=%0b", val, last));
      end else begin
        want = pending_bytes.pop_front();
        if (val !== want.value)
          report($sformatf("out_byte %02h, wanted %02h", val, want.value));
        if (last !== want.last)
          report($sformatf("last_of_run %0b, wanted %0b (byte %02h)", last, want.last, val));
      end
    endtask
  endclass
endpackage

/* tb/load_segment_record_framer_test.sv */
// Top-level test of the load segment record framer: directed and random requests.
module load_segment_record_framer_test;
  import lsrf_pkg::*;
  import lsrf_model_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 50;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  lsrf_in_if  in_ch ();
  lsrf_out_if out_ch ();

  load_segment_record_framer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  record_stream_model stream_model = new();

  int          cycle_count = 0;
  int          items_sent  = 0;
  bit          in_calm     = 1'b0;
  bit          out_calm    = 1'b0;
  logic [15:0] next_addr   = 16'h0000;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("load_segment_record_framer_test: errors");
      $finish;
    end
  end

  // Output side: random stalls per byte, with calm stretches.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      stream_model.check_byte(out_ch.out_byte, out_ch.last_of_run);
    end
  end

  task send_item(input logic act, input logic [15:0] addr, input logic [7:0] dat);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.address   <= addr;
    in_ch.data_byte <= dat;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    stream_model.take_item(act, addr, dat);
    items_sent++;
    if (act == ACT_DATA) next_addr = addr + 16'd1;
  endtask

  task send_flush();
    send_item(ACT_FLUSH, 16'($urandom), 8'($urandom));
  endtask

  task send_run(input logic [15:0] start, input int len);
    for (int i = 0; i < len; i++) send_item(ACT_DATA, start + 16'(i), 8'($urandom));
  endtask

  // Sender holds off until every framed byte is out, then lets the block settle.
  task wait_drained();
    in_ch.valid <= 1'b0;
    while (stream_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    stream_model.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_phase(input logic entry_flag, input logic [15:0] entry_val, input bit full_first);
    int          goal;
    int          pick;
    int          len;
    logic [15:0] start;
    wait_drained();
    write_reg(REG_HAS_ENTRY, {15'd0, entry_flag});
    write_reg(REG_ENTRY_ADDR, entry_val);
    goal = items_sent + PHASE_ITEMS;
    if (full_first) send_run(16'($urandom), 40);
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(0, 99);
        if (len < 70) len = $urandom_range(1, 8);
        else if (len < 90) len = $urandom_range(9, 31);
        else len = $urandom_range(32, 40);
        case ($urandom_range(0, 5))
          0: start = 16'hFFFF - 16'($urandom_range(0, 40));
          1: start = next_addr;
          default: start = 16'($urandom);
        endcase
        send_run(start, len);
      end else if (pick < 75) begin
        send_flush();
      end else if (pick < 90) begin
        send_item(ACT_DATA, 16'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        wait_drained();
      end else begin
        // repeat the last address: breaks the run
        send_item(ACT_DATA, next_addr - 16'd1, 8'($urandom));
      end
    end
    send_flush();
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_HAS_ENTRY;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_DATA;
    in_ch.address   <= '0;
    in_ch.data_byte <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // flush with nothing open and no entry point: no output at all
    send_flush();
    wait_drained();
    write_reg(REG_HAS_ENTRY, 16'd1);
    write_reg(REG_ENTRY_ADDR, 16'hFFFF);
    // flush with nothing open: entry record only
    send_item(ACT_FLUSH, 16'hFFFF, 8'hFF);
    // run at the top of memory, then wrap to zero starts a new run
    send_item(ACT_DATA, 16'hFFFE, 8'h00);
    send_item(ACT_DATA, 16'hFFFF, 8'hFF);
    send_item(ACT_DATA, 16'h0000, 8'hA5);
    send_item(ACT_DATA, 16'h0001, 8'h5A);
    // address jump closes the run
    send_item(ACT_DATA, 16'h8000, 8'hFF);
    send_item(ACT_DATA, 16'h8001, 8'h00);
    send_item(ACT_DATA, 16'h8002, 8'h81);
    send_item(ACT_DATA, 16'h8003, 8'h7E);
    send_item(ACT_FLUSH, 16'h0000, 8'h00);
    send_item(ACT_DATA, 16'h7FFF, 8'h00);
    send_item(ACT_DATA, 16'h7FFF, 8'hFF);
    send_item(ACT_FLUSH, 16'h5555, 8'hAA);
    send_item(ACT_DATA, 16'h0000, 8'h01);
    wait_drained();
    write_reg(REG_HAS_ENTRY, 16'd0);
    send_item(ACT_FLUSH, 16'hAAAA, 8'h55);

    // random phases across register settings; the first and fourth force a full-buffer split
    random_phase(1'b1, 16'hFFFF, 1'b1);
    random_phase(1'b0, 16'h0000, 1'b0);
    random_phase(1'b1, 16'h0000, 1'b0);
    random_phase(1'b1, 16'($urandom), 1'b1);
    random_phase(1'b0, 16'($urandom), 1'b0);
    random_phase(1'b1, 16'($urandom), 1'b0);

    wait_drained();
    if (stream_model.error_count == 0) begin
      $display("load_segment_record_framer_test: clean");
    end else begin
      $display("load_segment_record_framer_test: errors");
    end
    $finish;
  end
endmodule
